[rtl/gbn_pkg.sv]
// Shared types and constants for the go-back-N link endpoint.
package gbn_pkg;

    localparam int SEQ_BITS    = 3;
    localparam int PACKET_BITS = 32;

    typedef enum logic [1:0] {
        ACT_FRAME     = 2'd0,
        ACT_CKSUM_ERR = 2'd1,
        ACT_TIMEOUT   = 2'd2,
        ACT_PACKET    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ONE  = 2'd1,
        ST_STOP = 2'd2,
        ST_TX   = 2'd3
    } t_state;

endpackage

[rtl/gbn_in_if.sv]
// Event channel into the link endpoint.
interface gbn_in_if #(
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS,
    parameter int PACKET_BITS = gbn_pkg::PACKET_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             action;
    logic [PACKET_BITS-1:0] packet_data;
    logic [SEQ_BITS-1:0]    frame_seq;
    logic [SEQ_BITS-1:0]    frame_ack;
    logic [PACKET_BITS-1:0] frame_payload;

    modport source (
        output valid, action, packet_data, frame_seq, frame_ack, frame_payload,
        input  ready
    );
    modport sink (
        input  valid, action, packet_data, frame_seq, frame_ack, frame_payload,
        output ready
    );
endinterface

[rtl/gbn_out_if.sv]
// Result channel out of the link endpoint.
interface gbn_out_if #(
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS,
    parameter int PACKET_BITS = gbn_pkg::PACKET_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [SEQ_BITS-1:0]    seq_number;
    logic [SEQ_BITS-1:0]    ack_number;
    logic [PACKET_BITS-1:0] payload;
    logic                   network_enable;
    logic                   rejected;
    logic                   last;

    modport source (
        output valid, kind, seq_number, ack_number, payload, network_enable,
               rejected, last,
        input  ready
    );
    modport sink (
        input  valid, kind, seq_number, ack_number, payload, network_enable,
               rejected, last,
        output ready
    );
endinterface

[rtl/go_back_n_link_endpoint.sv]
// Go-back-N link endpoint: event sequencer around the send buffer RAM.
//
//   channel  direction  contents
//   i_in     in         event: action, packet_data, frame_seq, frame_ack, frame_payload
//   o_out    out        word: kind, seq_number, ack_number, payload, network_enable,
//                       rejected, last
//
// An event is taken only while the sequencer is idle; it then emits 1 to 2**SEQ_BITS
// words, one per cycle while o_out is ready, through a single output register.
// A timeout issues the first send buffer read as the event is taken, after which the
// read of the next frame overlaps the issue of the current one.
// A packet, status or delivery event with no releases emits a single word from ST_ONE.
// Reset is synchronous and empties the window; the send buffer is left as it is.
module go_back_n_link_endpoint #(
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS,
    parameter int PACKET_BITS = gbn_pkg::PACKET_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbn_in_if.sink     i_in,
    gbn_out_if.source  o_out
);
    import gbn_pkg::*;

    localparam int                  SeqMod = 1 << SEQ_BITS;
    localparam logic [SEQ_BITS-1:0] MaxSeq = SEQ_BITS'(SeqMod - 1);
    localparam logic [SEQ_BITS-1:0] One    = SEQ_BITS'(1);

    t_state                 r_state, n_state;
    logic [SEQ_BITS-1:0]    r_nts, n_nts;
    logic [SEQ_BITS-1:0]    r_old, n_old;
    logic [SEQ_BITS-1:0]    r_exp, n_exp;
    logic [SEQ_BITS-1:0]    r_cnt, n_cnt;
    logic [SEQ_BITS-1:0]    r_ptr, n_ptr;
    logic [SEQ_BITS-1:0]    r_rem, n_rem;

    t_kind                  r_hold_kind, n_hold_kind;
    logic [SEQ_BITS-1:0]    r_hold_seq, n_hold_seq;
    logic [SEQ_BITS-1:0]    r_hold_ack, n_hold_ack;
    logic [PACKET_BITS-1:0] r_hold_payload, n_hold_payload;
    logic                   r_hold_rej, n_hold_rej;

    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [SEQ_BITS-1:0]    r_out_seq, n_out_seq;
    logic [SEQ_BITS-1:0]    r_out_ack, n_out_ack;
    logic [PACKET_BITS-1:0] r_out_payload, n_out_payload;
    logic                   r_out_ne, n_out_ne;
    logic                   r_out_rej, n_out_rej;
    logic                   r_out_last, n_out_last;

    logic                   in_acc;
    logic                   out_free;
    logic                   load;
    logic [SEQ_BITS-1:0]    ack_now;
    logic [SEQ_BITS-1:0]    win_len;
    logic [SEQ_BITS-1:0]    ack_off;
    logic                   rel_hit;
    logic [SEQ_BITS-1:0]    rel_n;
    logic                   deliver;

    t_kind                  e_kind;
    logic [SEQ_BITS-1:0]    e_seq;
    logic [SEQ_BITS-1:0]    e_ack;
    logic [PACKET_BITS-1:0] e_payload;
    logic                   e_rej;
    logic                   e_last;

    logic                   wr_en;
    logic                   rd_en;
    logic [SEQ_BITS-1:0]    rd_addr;
    logic [PACKET_BITS-1:0] rd_data;

    gbn_ram #(
        .WIDTH (PACKET_BITS),
        .DEPTH (SeqMod)
    ) u_send_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_nts),
        .i_wr_data (i_in.packet_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign ack_now    = r_exp + MaxSeq;
    assign win_len    = r_nts - r_old;
    assign ack_off    = i_in.frame_ack - r_old;
    assign rel_hit    = (r_cnt != '0) && (ack_off < win_len);
    assign rel_n      = rel_hit ? ack_off + One : '0;
    assign deliver    = (i_in.frame_seq == r_exp);

    always_comb begin
        n_state        = r_state;
        n_nts          = r_nts;
        n_old          = r_old;
        n_exp          = r_exp;
        n_cnt          = r_cnt;
        n_ptr          = r_ptr;
        n_rem          = r_rem;
        n_hold_kind    = r_hold_kind;
        n_hold_seq     = r_hold_seq;
        n_hold_ack     = r_hold_ack;
        n_hold_payload = r_hold_payload;
        n_hold_rej     = r_hold_rej;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = r_ptr;
        load           = 1'b0;
        e_kind         = KIND_STATUS;
        e_seq          = '0;
        e_ack          = '0;
        e_payload      = '0;
        e_rej          = 1'b0;
        e_last         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_hold_kind    = KIND_STATUS;
                    n_hold_seq     = '0;
                    n_hold_ack     = '0;
                    n_hold_payload = '0;
                    n_hold_rej     = 1'b0;
                    n_rem          = '0;
                    n_state        = ST_ONE;
                    case (t_action'(i_in.action))
                        ACT_PACKET: begin
                            if (r_cnt != MaxSeq) begin
                                wr_en          = 1'b1;
                                n_cnt          = r_cnt + One;
                                n_nts          = r_nts + One;
                                n_hold_kind    = KIND_TX;
                                n_hold_seq     = r_nts;
                                n_hold_ack     = ack_now;
                                n_hold_payload = i_in.packet_data;
                            end else begin
                                n_hold_rej = 1'b1;
                            end
                        end
                        ACT_FRAME: begin
                            n_old = r_old + rel_n;
                            n_cnt = r_cnt - rel_n;
                            n_ptr = r_old;
                            n_rem = rel_n;
                            if (deliver) begin
                                n_exp          = r_exp + One;
                                n_hold_kind    = KIND_DELIVER;
                                n_hold_payload = i_in.frame_payload;
                            end else if (rel_hit) begin
                                n_state = ST_STOP;
                            end
                        end
                        ACT_TIMEOUT: begin
                            if (r_cnt != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_old;
                                n_ptr   = r_old;
                                n_rem   = r_cnt;
                                n_nts   = r_old + r_cnt;
                                n_state = ST_TX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ONE: begin
                e_kind    = r_hold_kind;
                e_seq     = r_hold_seq;
                e_ack     = r_hold_ack;
                e_payload = r_hold_payload;
                e_rej     = r_hold_rej;
                e_last    = (r_rem == '0);
                if (out_free) begin
                    load    = 1'b1;
                    n_state = (r_rem == '0) ? ST_IDLE : ST_STOP;
                end
            end
            ST_STOP: begin
                e_kind = KIND_STOP;
                e_seq  = r_ptr;
                e_last = (r_rem == One);
                if (out_free) begin
                    load  = 1'b1;
                    n_ptr = r_ptr + One;
                    n_rem = r_rem - One;
                    if (r_rem == One) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TX: begin
                e_kind    = KIND_TX;
                e_seq     = r_ptr;
                e_ack     = ack_now;
                e_payload = rd_data;
                e_last    = (r_rem == One);
                if (out_free) begin
                    load  = 1'b1;
                    n_ptr = r_ptr + One;
                    n_rem = r_rem - One;
                    if (r_rem == One) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_ptr + One;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
        n_out_kind    = load ? e_kind : r_out_kind;
        n_out_seq     = load ? e_seq : r_out_seq;
        n_out_ack     = load ? e_ack : r_out_ack;
        n_out_payload = load ? e_payload : r_out_payload;
        n_out_ne      = load ? (r_cnt != MaxSeq) : r_out_ne;
        n_out_rej     = load ? e_rej : r_out_rej;
        n_out_last    = load ? e_last : r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nts       <= '0;
            r_old       <= '0;
            r_exp       <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nts       <= n_nts;
            r_old       <= n_old;
            r_exp       <= n_exp;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_rem       <= n_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_kind    <= n_hold_kind;
        r_hold_seq     <= n_hold_seq;
        r_hold_ack     <= n_hold_ack;
        r_hold_payload <= n_hold_payload;
        r_hold_rej     <= n_hold_rej;
        r_out_kind     <= n_out_kind;
        r_out_seq      <= n_out_seq;
        r_out_ack      <= n_out_ack;
        r_out_payload  <= n_out_payload;
        r_out_ne       <= n_out_ne;
        r_out_rej      <= n_out_rej;
        r_out_last     <= n_out_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out_kind;
    assign o_out.seq_number     = r_out_seq;
    assign o_out.ack_number     = r_out_ack;
    assign o_out.payload        = r_out_payload;
    assign o_out.network_enable = r_out_ne;
    assign o_out.rejected       = r_out_rej;
    assign o_out.last           = r_out_last;
endmodule

[rtl/gbn_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module gbn_ram #(
    parameter int WIDTH = gbn_pkg::PACKET_BITS,
    parameter int DEPTH = 1 << gbn_pkg::SEQ_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[bench/tb.sv]
// Self-checking testbench for the go-back-N link endpoint, predicting every output word.
`timescale 1ns / 100ps

module tb;

    import gbn_pkg::*;

    localparam int MAX_OUT     = (1 << SEQ_BITS) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT       = 600000;
    localparam int PRINT_CAP   = 100;

    typedef logic [SEQ_BITS-1:0]    t_seq;
    typedef logic [PACKET_BITS-1:0] t_data;

    typedef struct packed {
        t_kind kind;
        t_seq  seq_number;
        t_seq  ack_number;
        t_data payload;
        logic  network_enable;
        logic  rejected;
        logic  last;
    } t_link_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbn_in_if  in_ch ();
    gbn_out_if out_ch ();

    go_back_n_link_endpoint u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    t_seq       tx_next;
    t_seq       tx_oldest;
    t_seq       rx_expected;
    t_seq       tx_count;
    t_data      tx_store [1 << SEQ_BITS];
    t_link_word pending_words [$];

    int   error_count = 0;
    int   cycle_count = 0;
    int   hold_req    = 0;
    logic gaps_on     = 1'b1;

    function automatic int pick_gap();
        int unsigned r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // True when low <= probe < high, going round the sequence space.
    function automatic logic seq_in_window(t_seq low, t_seq probe, t_seq high);
        return ((low <= probe) && (probe < high)) || ((high < low) && (low <= probe)) ||
               ((probe < high) && (high < low));
    endfunction

    function automatic t_link_word make_word(t_kind kind, t_seq seq, t_seq ack,
                                             t_data payload, logic rejected);
        t_link_word w;
        w.kind           = kind;
        w.seq_number     = seq;
        w.ack_number     = ack;
        w.payload        = payload;
        w.network_enable = 1'b0;
        w.rejected       = rejected;
        w.last           = 1'b0;
        return w;
    endfunction

    function automatic t_link_word frame_out_word();
        t_link_word w;
        w = make_word(KIND_TX, tx_next, t_seq'(rx_expected - 1), tx_store[tx_next], 1'b0);
        tx_next = t_seq'(tx_next + 1);
        return w;
    endfunction

    function automatic void apply_link_event(t_action act, t_data pdata, t_seq fseq,
                                             t_seq fack, t_data fpay);
        t_link_word words [$];
        t_link_word w;
        int         resend;
        if (act == ACT_PACKET) begin
            if (tx_count < MAX_OUT) begin
                tx_store[tx_next] = pdata;
                tx_count = t_seq'(tx_count + 1);
                words.push_back(frame_out_word());
            end else begin
                words.push_back(make_word(KIND_STATUS, '0, '0, '0, 1'b1));
            end
        end else if (act == ACT_FRAME) begin
            if (fseq == rx_expected) begin
                words.push_back(make_word(KIND_DELIVER, '0, '0, fpay, 1'b0));
                rx_expected = t_seq'(rx_expected + 1);
            end
            while (tx_count > 0 && seq_in_window(tx_oldest, fack, tx_next)) begin
                tx_count = t_seq'(tx_count - 1);
                words.push_back(make_word(KIND_STOP, tx_oldest, '0, '0, 1'b0));
                tx_oldest = t_seq'(tx_oldest + 1);
            end
        end else if (act == ACT_TIMEOUT) begin
            resend = int'(tx_count);
            tx_next = tx_oldest;
            repeat (resend) words.push_back(frame_out_word());
        end
        if (words.size() == 0) begin
            words.push_back(make_word(KIND_STATUS, '0, '0, '0, 1'b0));
        end
        foreach (words[i]) begin
            w = words[i];
            w.network_enable = (tx_count < MAX_OUT);
            w.last           = (i == words.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic check_word();
        t_link_word want;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("word of kind %0d with nothing expected", out_ch.kind));
            return;
        end
        want = pending_words.pop_front();
        compare_field("kind", 64'(out_ch.kind), 64'(want.kind));
        compare_field("seq_number", 64'(out_ch.seq_number), 64'(want.seq_number));
        compare_field("ack_number", 64'(out_ch.ack_number), 64'(want.ack_number));
        compare_field("payload", 64'(out_ch.payload), 64'(want.payload));
        compare_field("network_enable", 64'(out_ch.network_enable),
                      64'(want.network_enable));
        compare_field("rejected", 64'(out_ch.rejected), 64'(want.rejected));
        compare_field("last", 64'(out_ch.last), 64'(want.last));
    endtask

    task automatic send_event(t_action act, t_data pdata, t_seq fseq, t_seq fack,
                              t_data fpay);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.packet_data   <= pdata;
        in_ch.frame_seq     <= fseq;
        in_ch.frame_ack     <= fack;
        in_ch.frame_payload <= fpay;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        apply_link_event(act, pdata, fseq, fack, fpay);
    endtask

    task automatic send_packet(t_data pdata);
        send_event(ACT_PACKET, pdata, t_seq'($urandom), t_seq'($urandom), t_data'($urandom));
    endtask

    task automatic send_frame(t_seq fseq, t_seq fack, t_data fpay);
        send_event(ACT_FRAME, t_data'($urandom), fseq, fack, fpay);
    endtask

    task automatic send_plain(t_action act);
        send_event(act, t_data'($urandom), t_seq'($urandom), t_seq'($urandom),
                   t_data'($urandom));
    endtask

    task automatic test_quiet_events();
        send_plain(ACT_CKSUM_ERR);
        send_plain(ACT_TIMEOUT);
        send_frame(t_seq'(rx_expected + 1), t_seq'($urandom), t_data'($urandom));
    endtask

    task automatic test_packet_extremes();
        send_packet('0);
        send_packet('1);
        send_packet(32'hA5A5_A5A5);
        send_packet(32'h5A5A_5A5A);
    endtask

    task automatic test_inbound_frames();
        send_frame(rx_expected, tx_oldest, '1);
        send_frame(rx_expected, t_seq'(tx_oldest - 1), '0);
        send_frame(t_seq'(rx_expected + 3), tx_next, t_data'($urandom));
    endtask

    task automatic test_timeout_resend();
        send_plain(ACT_TIMEOUT);
    endtask

    task automatic test_window_full();
        while (tx_count < MAX_OUT) send_packet(t_data'($urandom));
        send_packet('1);
        send_packet(t_data'($urandom));
        send_plain(ACT_TIMEOUT);
        send_frame(rx_expected, t_seq'(tx_next - 1), t_data'($urandom));
    endtask

    task automatic test_random_traffic(int count);
        int unsigned r;
        t_seq        fseq;
        t_seq        fack;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 42) begin
                send_packet(t_data'($urandom));
            end else if (r < 85) begin
                fseq = ($urandom_range(0, 3) != 0) ? rx_expected : t_seq'($urandom);
                if (tx_count != 0 && $urandom_range(0, 3) != 0) begin
                    fack = t_seq'(tx_oldest + $urandom_range(0, int'(tx_count) - 1));
                end else begin
                    fack = t_seq'($urandom);
                end
                send_frame(fseq, fack, t_data'($urandom));
            end else if (r < 93) begin
                send_plain(ACT_TIMEOUT);
            end else begin
                send_plain(ACT_CKSUM_ERR);
            end
        end
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req <= hold_req + 1;
        test_random_traffic(20);
        gaps_on  = 1'b1;
    endtask

    initial begin : out_sink
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left   = 0;
        hold_left    = 0;
        hold_seen    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                check_word();
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (i_rst_n !== 1'b1) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        tx_next             = '0;
        tx_oldest           = '0;
        rx_expected         = '0;
        tx_count            = '0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ACT_CKSUM_ERR;
        in_ch.packet_data   <= '0;
        in_ch.frame_seq     <= '0;
        in_ch.frame_ack     <= '0;
        in_ch.frame_payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_quiet_events();
        test_packet_extremes();
        test_inbound_frames();
        test_timeout_resend();
        test_window_full();
        test_random_traffic(180);
        test_backpressure();
        gaps_on = 1'b0;
        test_random_traffic(80);
        gaps_on = 1'b1;
        test_random_traffic(20);

        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
